@@ hw/rtl/c_source_whole_word_token_finder_core_assert.svh @@
// Assertion macros used by the checker of the token finder.
// IMPLY: condition holds in the same cycle as the trigger.
// NEXT: condition holds in the cycle after the trigger.
`ifndef C_SOURCE_WHOLE_WORD_TOKEN_FINDER_CORE_ASSERT_SVH
`define C_SOURCE_WHOLE_WORD_TOKEN_FINDER_CORE_ASSERT_SVH

`define CSWTF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("token finder check failed (same cycle)");

`define CSWTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("token finder check failed (next cycle)");

`endif

@@ hw/rtl/cswtf_pkg.sv @@
package cswtf_pkg;

    // Lexer modes
    typedef enum logic [2:0] {
        LEX_CODE  = 3'd0,
        LEX_LINE  = 3'd1,
        LEX_BLOCK = 3'd2,
        LEX_STR   = 3'd3,
        LEX_CHR   = 3'd4
    } lex_mode_t;

    // Characters the lexer reacts to
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    // Register map
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int TOKEN_LEN_W = 6;
    localparam int TOKEN_WORDS = 4;
    localparam int TOKEN_BYTES = TOKEN_WORDS * 8;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_TOKEN_LEN     = 3'd0;
    localparam reg_idx_t REG_TOKEN_BYTES_0 = 3'd1;
    localparam reg_idx_t REG_TOKEN_BYTES_1 = 3'd2;
    localparam reg_idx_t REG_TOKEN_BYTES_2 = 3'd3;
    localparam reg_idx_t REG_TOKEN_BYTES_3 = 3'd4;

    // Match-start marks the lexer raises for the current beat
    typedef struct packed {
        logic se_cur;   // current byte may start a match
        logic se_prev;  // the pending slash before it may start a match
    } lex_start_t;

    function automatic logic is_ident(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || (b == CH_UNDERSCORE);
    endfunction

endpackage

@@ hw/rtl/cswtf_lexer.sv @@
module cswtf_lexer (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  beat_valid,
    input  logic [7:0]            byte_in,
    input  logic                  eof,
    input  logic                  at_first,   // no byte of this file seen yet
    input  logic                  at_second,  // exactly one byte seen
    output cswtf_pkg::lex_start_t start
);

    cswtf_pkg::lex_mode_t mode_reg, mode_next;
    logic slash_reg, slash_next;
    logic skip_reg, skip_next;
    logic star_reg, star_next;
    logic ident0_reg, ident1_reg;   // identifier flags of the last two bytes

    // Classify the incoming byte and advance the lexer
    always_comb begin
        logic fresh;
        mode_next     = mode_reg;
        slash_next    = slash_reg;
        skip_next     = skip_reg;
        star_next     = star_reg;
        fresh         = 1'b0;
        start.se_cur  = 1'b0;
        start.se_prev = 1'b0;

        if (mode_reg == cswtf_pkg::LEX_CODE && slash_reg) begin
            slash_next = 1'b0;
            if (byte_in == cswtf_pkg::CH_SLASH) begin
                mode_next = cswtf_pkg::LEX_LINE;
            end else if (byte_in == cswtf_pkg::CH_STAR) begin
                mode_next = cswtf_pkg::LEX_BLOCK;
                star_next = 1'b0;
            end else begin
                // lone slash was code after all
                start.se_prev = at_second || !ident1_reg;
                fresh         = 1'b1;
            end
        end else if (skip_reg) begin
            skip_next = 1'b0;
        end else begin
            case (mode_reg)
                cswtf_pkg::LEX_LINE: begin
                    if (byte_in == cswtf_pkg::CH_NEWLINE) mode_next = cswtf_pkg::LEX_CODE;
                end
                cswtf_pkg::LEX_BLOCK: begin
                    if (star_reg && byte_in == cswtf_pkg::CH_SLASH) begin
                        mode_next = cswtf_pkg::LEX_CODE;
                        star_next = 1'b0;
                    end else begin
                        star_next = (byte_in == cswtf_pkg::CH_STAR);
                    end
                end
                cswtf_pkg::LEX_STR: begin
                    if (byte_in == cswtf_pkg::CH_BSLASH) skip_next = 1'b1;
                    else if (byte_in == cswtf_pkg::CH_DQUOTE) mode_next = cswtf_pkg::LEX_CODE;
                end
                cswtf_pkg::LEX_CHR: begin
                    if (byte_in == cswtf_pkg::CH_BSLASH) skip_next = 1'b1;
                    else if (byte_in == cswtf_pkg::CH_SQUOTE) mode_next = cswtf_pkg::LEX_CODE;
                end
                default: begin
                    mode_next = cswtf_pkg::LEX_CODE;
                    fresh     = 1'b1;
                end
            endcase
        end

        // byte read in code state: open a literal, hold a slash, or mark a start
        if (fresh) begin
            if (byte_in == cswtf_pkg::CH_DQUOTE) begin
                mode_next = cswtf_pkg::LEX_STR;
            end else if (byte_in == cswtf_pkg::CH_SQUOTE) begin
                mode_next = cswtf_pkg::LEX_CHR;
            end else if (byte_in == cswtf_pkg::CH_SLASH && !eof) begin
                slash_next = 1'b1;
            end else begin
                start.se_cur = at_first || !ident0_reg;
            end
        end

        // drop the mode, slash, skip and star state at the end of the file
        if (eof) begin
            mode_next  = cswtf_pkg::LEX_CODE;
            slash_next = 1'b0;
            skip_next  = 1'b0;
            star_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= cswtf_pkg::LEX_CODE;
            slash_reg <= 1'b0;
            skip_reg  <= 1'b0;
            star_reg  <= 1'b0;
        end else if (beat_valid) begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            skip_reg  <= skip_next;
            star_reg  <= star_next;
        end
    end

    // identifier flags only matter once the byte count says they were loaded
    always_ff @(posedge aclk) begin
        if (beat_valid) begin
            ident0_reg <= cswtf_pkg::is_ident(byte_in);
            ident1_reg <= ident0_reg;
        end
    end

endmodule

@@ hw/rtl/c_source_whole_word_token_finder_core.sv @@
// Whole-word token finder for C/C++ source: takes one byte of a source file per
// beat on the s_ channel (s_tlast on the final byte) and, in the cycle after the
// final byte is taken, offers one m_ beat whose bit 0 says whether the token set
// in the registers occurs as a whole word starting in code (outside comments,
// string and char literals). A byte is taken every clock while s_tready is high;
// the lexer update and a compare of the token against the last bytes are
// combinational. s_tready is low for one cycle after reset and after each
// register write while the aligned token pattern register reloads, and while a
// result waits with m_tready low. No clearing pass is needed.
module c_source_whole_word_token_finder_core #(
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] src_byte
    input  logic                             s_tlast,   // end_of_file
    // result
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [0] found, [7:1] zero
    // registers
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cswtf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [cswtf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [cswtf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int T_W   = $clog2(MAX_TOKEN_LEN + 1);
    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 2);
    localparam int JW    = (T_W > 5) ? T_W : 5;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_LEN + 1);

    // ---------------------------------------------------------------- registers
    logic [cswtf_pkg::TOKEN_LEN_W-1:0] tok_len_reg;
    logic [cswtf_pkg::CFG_DATA_W-1:0]  tok_word_reg [cswtf_pkg::TOKEN_WORDS];
    logic                              cfg_wr;
    cswtf_pkg::reg_idx_t               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_len_reg <= cswtf_pkg::TOKEN_LEN_W'(1);
            for (int w = 0; w < cswtf_pkg::TOKEN_WORDS; w++) begin
                tok_word_reg[w] <= '0;
            end
        end else if (cfg_wr) begin
            case (cfg_idx)
                cswtf_pkg::REG_TOKEN_LEN:     tok_len_reg     <= pwdata[cswtf_pkg::TOKEN_LEN_W-1:0];
                cswtf_pkg::REG_TOKEN_BYTES_0: tok_word_reg[0] <= pwdata;
                cswtf_pkg::REG_TOKEN_BYTES_1: tok_word_reg[1] <= pwdata;
                cswtf_pkg::REG_TOKEN_BYTES_2: tok_word_reg[2] <= pwdata;
                cswtf_pkg::REG_TOKEN_BYTES_3: tok_word_reg[3] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            cswtf_pkg::REG_TOKEN_LEN:
                prdata = cswtf_pkg::CFG_DATA_W'(tok_len_reg);
            cswtf_pkg::REG_TOKEN_BYTES_0: prdata = tok_word_reg[0];
            cswtf_pkg::REG_TOKEN_BYTES_1: prdata = tok_word_reg[1];
            cswtf_pkg::REG_TOKEN_BYTES_2: prdata = tok_word_reg[2];
            cswtf_pkg::REG_TOKEN_BYTES_3: prdata = tok_word_reg[3];
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------- aligned pattern
    // q[k] is the byte expected k places back from the newest compared byte,
    // i.e. token byte t-1-k; m[k] marks the places inside the token.
    logic [T_W-1:0] t_len;
    logic [7:0]     tok_byte [cswtf_pkg::TOKEN_BYTES];
    logic [7:0]     q_next [MAX_TOKEN_LEN];
    logic [7:0]     q_reg  [MAX_TOKEN_LEN];
    logic [MAX_TOKEN_LEN-1:0] m_next, m_reg;
    logic           hold_reg;

    always_comb begin
        if (int'(tok_len_reg) > MAX_TOKEN_LEN) t_len = T_W'(MAX_TOKEN_LEN);
        else t_len = T_W'(tok_len_reg);
    end

    always_comb begin
        for (int i = 0; i < cswtf_pkg::TOKEN_BYTES; i++) begin
            tok_byte[i] = tok_word_reg[i / 8][(i % 8) * 8 +: 8];
        end
    end

    always_comb begin
        logic [JW-1:0] j;
        for (int k = 0; k < MAX_TOKEN_LEN; k++) begin
            j         = JW'(t_len) - JW'(k) - JW'(1);
            m_next[k] = (k < int'(t_len));
            if (m_next[k] && int'(j) < cswtf_pkg::TOKEN_BYTES) q_next[k] = tok_byte[j[4:0]];
            else q_next[k] = 8'h00;
        end
    end

    // reload every cycle; hold input off the cycle after reset or a write
    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        m_reg <= m_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) hold_reg <= 1'b1;
        else hold_reg <= cfg_wr;
    end

    // ---------------------------------------------------------- byte datapath
    logic                     m_valid_reg;
    logic                     found_reg;
    logic                     s_fire;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     match_reg;
    logic [7:0]               hist_reg [MAX_TOKEN_LEN];
    logic [MAX_TOKEN_LEN-1:0] se_reg;
    logic [MAX_TOKEN_LEN:0]   se_new;
    logic [MAX_TOKEN_LEN-1:0] eq_prev, eq_last;
    cswtf_pkg::lex_start_t    start;
    logic                     hit_prev, hit_last, match_next;

    assign s_tready = !hold_reg && (!m_valid_reg || m_tready);
    assign s_fire   = s_tvalid && s_tready;

    cswtf_lexer u_lexer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_valid (s_fire),
        .byte_in    (s_tdata),
        .eof        (s_tlast),
        .at_first   (cnt_reg == '0),
        .at_second  (cnt_reg == CNT_W'(1)),
        .start      (start)
    );

    // start marks after this beat's shift
    always_comb begin
        se_new[0] = start.se_cur;
        se_new[1] = se_reg[0] | start.se_prev;
        for (int i = 2; i <= MAX_TOKEN_LEN; i++) begin
            se_new[i] = se_reg[i-1];
        end
    end

    // compare the token against the window ending before and on this byte
    always_comb begin
        for (int k = 0; k < MAX_TOKEN_LEN; k++) begin
            eq_prev[k] = (hist_reg[k] == q_reg[k]) || !m_reg[k];
            if (k == 0) eq_last[k] = (s_tdata == q_reg[k]) || !m_reg[k];
            else eq_last[k] = (hist_reg[(k > 0) ? k - 1 : 0] == q_reg[k]) || !m_reg[k];
        end
    end

    always_comb begin
        hit_prev = (t_len != '0) && (cnt_reg >= CNT_W'(t_len)) && se_new[t_len] &&
                   !cswtf_pkg::is_ident(s_tdata) && (&eq_prev);
        hit_last = (t_len != '0) && s_tlast &&
                   ((CNT_W+1)'(cnt_reg) + (CNT_W+1)'(1) >= (CNT_W+1)'(t_len)) &&
                   se_new[t_len - T_W'(1)] && (&eq_last);
        match_next = match_reg || hit_prev || hit_last;
    end

    // advance count, start marks and hit flag; drop them after the final byte (history shifts below)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            match_reg <= 1'b0;
            se_reg    <= '0;
        end else if (s_fire) begin
            if (s_tlast) begin
                cnt_reg   <= '0;
                match_reg <= 1'b0;
                se_reg    <= '0;
            end else begin
                if (cnt_reg < CNT_MAX) cnt_reg <= cnt_reg + CNT_W'(1);
                match_reg <= match_next;
                se_reg    <= se_new[MAX_TOKEN_LEN-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hist_reg[0] <= s_tdata;
            for (int i = 1; i < MAX_TOKEN_LEN; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // result slot: load on the final byte, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_tlast) found_reg <= match_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, found_reg};

endmodule

@@ hw/rtl/cswtf_checker.sv @@
`include "c_source_whole_word_token_finder_core_assert.svh"

module cswtf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       psel,
    input logic       penable,
    input logic       pwrite,
    input logic       pready
);

    // a stalled result beat holds
    `CSWTF_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // only bit 0 carries information
    `CSWTF_ASSERT_IMPLY(a_result_pad, aclk, aresetn, m_tvalid, m_tdata[7:1] == 7'd0)

    // a result appears only after a final byte was taken
    `CSWTF_ASSERT_IMPLY(a_result_cause, aclk, aresetn, $rose(m_tvalid), $past(s_tvalid && s_tready && s_tlast))

    // a taken result is replaced only by a new final byte
    `CSWTF_ASSERT_NEXT(a_result_refill, aclk, aresetn, m_tvalid && m_tready, !m_tvalid || $past(s_tvalid && s_tready && s_tlast))

    // input stalls while the pattern reloads after a register write
    `CSWTF_ASSERT_NEXT(a_cfg_stall, aclk, aresetn, psel && penable && pwrite && pready, !s_tready)

endmodule

bind c_source_whole_word_token_finder_core cswtf_checker u_cswtf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready)
);
